// ===== rtl/spsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo pulse sweep generator package
// Shared types, codes and reset constants for the servo pulse sweep generator.
// ----------------------------------------------------------------------------
package spsg_pkg;

    // Field widths.
    localparam int GAIN_W   = 8;
    localparam int OFFSET_W = 15;
    localparam int ANGLE_W  = 9;
    localparam int PERIOD_W = 16;
    localparam int STEP_W   = 10;
    localparam int MSEC_W   = 20;
    localparam int WIDTH_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Width of the shared divider operands.
    localparam int DIV_W = 20;

    // Reset values of the configuration registers and of the state.
    localparam logic [GAIN_W-1:0]   GAIN_RESET      = 8'd10;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET    = 15'd600;
    localparam logic [ANGLE_W-1:0]  MIN_ANGLE_RESET = 9'd0;
    localparam logic [ANGLE_W-1:0]  MAX_ANGLE_RESET = 9'd180;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd20000;
    localparam logic [STEP_W-1:0]   STEP_RESET      = 10'd20;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 16'd1590;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd5;

    // Action codes of an input item.
    localparam logic [1:0] ACT_EDGE     = 2'd0;
    localparam logic [1:0] ACT_POSITION = 2'd1;
    localparam logic [1:0] ACT_SWEEP    = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MAP,
        S_DIV_STEPS,
        S_WAIT_STEPS,
        S_DIV_DELTA,
        S_WAIT_DELTA,
        S_FINISH
    } state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage : spsg_pkg
`default_nettype wire

// ===== rtl/spsg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo sweep divider
// Unsigned restoring divider, one quotient bit per cycle, shared by the
// sweep step count and the per-period width change.
// ----------------------------------------------------------------------------
module spsg_div
    import spsg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DIV_W - 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [DIV_W:0]   rem_reg;
    logic [DIV_W:0]   rem_next;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] quo_next;
    logic [DIV_W-1:0] divisor_reg;
    logic [DIV_W-1:0] divisor_next;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        shifted = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        trial   = shifted - {1'b0, divisor_reg};

        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;

        if (req.start && !busy_reg)
        begin
            busy_next    = 1'b1;
            count_next   = LAST_BIT;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule : spsg_div
`default_nettype wire

// ===== rtl/servo_pulse_sweep_generator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An edge event that opens a period during a sweep passes from input transfer to result
// through the shared divider twice, first for the step count, then for the width change.
// Other edge events and rejected commands go from decode to finish; accepted commands also pass the map state.
// Throughput: one item at a time; the input is ready again once the result is registered.
// Reset (rst_n, asynchronous, active low) loads the register defaults, a pulse width of
// 1590 ticks, no sweep and a low line; the configuration port is always ready.
// ----------------------------------------------------------------------------
// Servo pulse sweep generator
// Produces servo output-compare edge intervals, maps angle commands to pulse
// widths and ramps the width linearly toward a target during a sweep.
// ----------------------------------------------------------------------------
module servo_pulse_sweep_generator_top
    import spsg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            action,
    input  wire logic [ANGLE_W-1:0]    angle,
    input  wire logic [MSEC_W-1:0]     sweep_time_ms,
    // Output channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       next_level,
    output logic [WIDTH_W-1:0]         interval,
    output logic [WIDTH_W-1:0]         width_now,
    output logic                       sweeping,
    output logic                       rejected
);

    // Configuration registers.
    logic [GAIN_W-1:0]          gain_reg;
    logic [OFFSET_W-1:0]        offset_reg;
    logic signed [ANGLE_W-1:0]  min_angle_reg;
    logic signed [ANGLE_W-1:0]  max_angle_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic [STEP_W-1:0]          step_reg;

    // Generator state.
    logic [WIDTH_W-1:0]         pulse_width_reg;
    logic [WIDTH_W-1:0]         pulse_width_next;
    logic [WIDTH_W-1:0]         target_pulse_reg;
    logic [WIDTH_W-1:0]         target_pulse_next;
    logic [MSEC_W-1:0]          remaining_reg;
    logic [MSEC_W-1:0]          remaining_next;
    logic                       sweep_active_reg;
    logic                       sweep_active_next;
    logic                       line_high_reg;
    logic                       line_high_next;

    // Sequencer.
    state_t                     state_reg;
    state_t                     state_next;

    // Latched input item and working values.
    logic [1:0]                 action_reg;
    logic signed [ANGLE_W-1:0]  angle_reg;
    logic [MSEC_W-1:0]          msecs_reg;
    logic                       reject_reg;
    logic                       reject_next;
    logic                       do_sweep_reg;
    logic                       do_sweep_next;
    logic signed [17:0]         prod_reg;
    logic [WIDTH_W-1:0]         mapped_reg;
    logic [WIDTH_W-1:0]         mapped_next;
    logic [DIV_W-1:0]           steps_reg;
    logic                       diff_neg_reg;
    logic [WIDTH_W-1:0]         quo_reg;

    // Output register.
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       next_level_reg;
    logic [WIDTH_W-1:0]         interval_reg;
    logic [WIDTH_W-1:0]         interval_next;
    logic [WIDTH_W-1:0]         width_now_reg;
    logic                       sweeping_reg;
    logic                       rejected_reg;

    // Sequencer outputs.
    logic                       commit;
    logic                       slot_free;
    logic                       in_xfer;
    logic                       div_start;

    // Shared divider.
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    // Combinational datapath values.
    logic                       out_of_range;
    logic signed [17:0]         gain_s;
    logic signed [17:0]         angle_s;
    logic signed [18:0]         map_sum;
    logic [STEP_W-1:0]          step_eff;
    logic signed [WIDTH_W:0]    diff;
    logic [WIDTH_W-1:0]         abs_diff;
    logic [WIDTH_W-1:0]         delta;
    logic [WIDTH_W-1:0]         swept_width;
    logic [MSEC_W-1:0]          swept_remaining;

    spsg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (do_sweep_next)
                begin
                    state_next = S_DIV_STEPS;
                end
                else if ((action_reg == ACT_POSITION || action_reg == ACT_SWEEP)
                         && !out_of_range)
                begin
                    state_next = S_MAP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MAP:
            begin
                state_next = S_FINISH;
            end
            S_DIV_STEPS:
            begin
                state_next = S_WAIT_STEPS;
            end
            S_WAIT_STEPS:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DIV_DELTA;
                end
            end
            S_DIV_DELTA:
            begin
                state_next = S_WAIT_DELTA;
            end
            S_WAIT_DELTA:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        commit    = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_DIV_STEPS,
            S_DIV_DELTA:
            begin
                div_start = 1'b1;
            end
            S_FINISH:
            begin
                commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Divider operands: step count first, then the width change.
    always_comb
    begin
        div_req.start = div_start;
        step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;
        diff     = $signed({1'b0, target_pulse_reg}) - $signed({1'b0, pulse_width_reg});
        abs_diff = diff[WIDTH_W] ? WIDTH_W'(-diff) : diff[WIDTH_W-1:0];
        if (state_reg == S_DIV_STEPS)
        begin
            div_req.dividend = remaining_reg;
            div_req.divisor  = {{(DIV_W-STEP_W){1'b0}}, step_eff};
        end
        else
        begin
            div_req.dividend = {{(DIV_W-WIDTH_W){1'b0}}, abs_diff};
            div_req.divisor  = steps_reg;
        end
    end

    // Angle check and mapping of the angle to a pulse width.
    always_comb
    begin
        out_of_range = (angle_reg < min_angle_reg) || (angle_reg > max_angle_reg);
        reject_next  = (action_reg == ACT_POSITION || action_reg == ACT_SWEEP)
                       && out_of_range;
        do_sweep_next = (action_reg == ACT_EDGE) && !line_high_reg && sweep_active_reg;
        gain_s  = $signed({{(18-GAIN_W){1'b0}}, gain_reg});
        angle_s = $signed({{(18-ANGLE_W){angle_reg[ANGLE_W-1]}}, angle_reg});
        map_sum = $signed({prod_reg[17], prod_reg})
                  + $signed({{(19-OFFSET_W){1'b0}}, offset_reg});
        if (map_sum < 0)
        begin
            mapped_next = '0;
        end
        else if (map_sum[17:0] > {2'b00, period_reg})
        begin
            mapped_next = period_reg;
        end
        else
        begin
            mapped_next = map_sum[WIDTH_W-1:0];
        end
    end

    // State update and result values for the item in hand.
    always_comb
    begin
        delta           = diff_neg_reg ? WIDTH_W'(-quo_reg) : quo_reg;
        swept_width     = pulse_width_reg + delta;
        swept_remaining = (remaining_reg > {{(MSEC_W-STEP_W){1'b0}}, step_eff})
                          ? remaining_reg - {{(MSEC_W-STEP_W){1'b0}}, step_eff}
                          : '0;

        pulse_width_next  = pulse_width_reg;
        target_pulse_next = target_pulse_reg;
        remaining_next    = remaining_reg;
        sweep_active_next = sweep_active_reg;
        line_high_next    = line_high_reg;
        interval_next     = '0;

        case (action_reg)
            ACT_EDGE:
            begin
                if (!line_high_reg)
                begin
                    if (do_sweep_reg)
                    begin
                        pulse_width_next = swept_width;
                        remaining_next   = swept_remaining;
                        if (swept_width == target_pulse_reg)
                        begin
                            sweep_active_next = 1'b0;
                        end
                    end
                    interval_next  = (period_reg > pulse_width_next)
                                     ? period_reg - pulse_width_next : '0;
                    line_high_next = 1'b1;
                end
                else
                begin
                    interval_next  = pulse_width_reg;
                    line_high_next = 1'b0;
                end
            end
            ACT_POSITION:
            begin
                if (!reject_reg)
                begin
                    pulse_width_next  = mapped_reg;
                    sweep_active_next = 1'b0;
                end
            end
            ACT_SWEEP:
            begin
                if (!reject_reg)
                begin
                    target_pulse_next = mapped_reg;
                    remaining_next    = msecs_reg;
                    sweep_active_next = 1'b1;
                end
            end
            default:
            begin
                interval_next = '0;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control, configuration and generator state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            gain_reg         <= GAIN_RESET;
            offset_reg       <= OFFSET_RESET;
            min_angle_reg    <= MIN_ANGLE_RESET;
            max_angle_reg    <= MAX_ANGLE_RESET;
            period_reg       <= PERIOD_RESET;
            step_reg         <= STEP_RESET;
            pulse_width_reg  <= WIDTH_RESET;
            target_pulse_reg <= '0;
            remaining_reg    <= '0;
            sweep_active_reg <= 1'b0;
            line_high_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GAIN:      gain_reg      <= cfg_data[GAIN_W-1:0];
                    CFG_OFFSET:    offset_reg    <= cfg_data[OFFSET_W-1:0];
                    CFG_MIN_ANGLE: min_angle_reg <= cfg_data[ANGLE_W-1:0];
                    CFG_MAX_ANGLE: max_angle_reg <= cfg_data[ANGLE_W-1:0];
                    CFG_PERIOD:    period_reg    <= cfg_data[PERIOD_W-1:0];
                    CFG_STEP:      step_reg      <= cfg_data[STEP_W-1:0];
                    default:       gain_reg      <= gain_reg;
                endcase
            end
            if (commit)
            begin
                pulse_width_reg  <= pulse_width_next;
                target_pulse_reg <= target_pulse_next;
                remaining_reg    <= remaining_next;
                sweep_active_reg <= sweep_active_next;
                line_high_reg    <= line_high_next;
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            action_reg <= action;
            angle_reg  <= angle;
            msecs_reg  <= sweep_time_ms;
        end
        if (state_reg == S_DECODE)
        begin
            reject_reg   <= reject_next;
            do_sweep_reg <= do_sweep_next;
            prod_reg     <= gain_s * angle_s;
        end
        if (state_reg == S_MAP)
        begin
            mapped_reg <= mapped_next;
        end
        if (state_reg == S_WAIT_STEPS && div_rsp.done)
        begin
            steps_reg <= (div_rsp.quotient == '0) ? DIV_W'(1) : div_rsp.quotient;
        end
        if (state_reg == S_DIV_DELTA)
        begin
            diff_neg_reg <= diff[WIDTH_W];
        end
        if (state_reg == S_WAIT_DELTA && div_rsp.done)
        begin
            quo_reg <= div_rsp.quotient[WIDTH_W-1:0];
        end
        if (commit)
        begin
            next_level_reg <= line_high_next;
            interval_reg   <= interval_next;
            width_now_reg  <= pulse_width_next;
            sweeping_reg   <= sweep_active_next;
            rejected_reg   <= reject_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_level = next_level_reg;
    assign interval   = interval_reg;
    assign width_now  = width_now_reg;
    assign sweeping   = sweeping_reg;
    assign rejected   = rejected_reg;

    // The divider is never started while it is still working.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // The width change is never divided by a zero step count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_DELTA) |-> (steps_reg != '0))
        else $error("zero step count reached the divider");

    // A result is never written over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> !$past(commit))
        else $error("pending result overwritten");

    // A new item is never taken while the divider still works on the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !div_rsp.busy)
        else $error("input transfer during a division");

endmodule : servo_pulse_sweep_generator_top
`default_nettype wire
